@@ hdl/lcas_pkg.sv @@
// ---------------------------------------------------------------------------
// lcas_pkg
// Shared types and constants for the load-cell averaging and stability core
// ---------------------------------------------------------------------------
package lcas_pkg;

    localparam int AVG_DEPTH  = 8;
    localparam int HIST_DEPTH = 16;

    localparam int AVG_IW  = (AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 1;
    localparam int AVG_FW  = $clog2(AVG_DEPTH + 1);
    localparam int HIST_IW = $clog2(HIST_DEPTH);
    localparam int HIST_FW = $clog2(HIST_DEPTH + 1);

    localparam int GRAM_W = 32;
    localparam int SUM_W  = GRAM_W + 1 + AVG_IW;
    localparam int DIV_W  = SUM_W + 5;
    localparam int DIV_CW = $clog2(DIV_W);
    localparam int PROD_W = 57;

    localparam int RAW_W    = 24;
    localparam int TENTHS_W = 21;
    localparam int CFG_IW   = 2;
    localparam int CFG_DW   = 32;

    localparam int TENTHS_MAX = 1000000;
    localparam int HIST_MIN   = 5;
    localparam int CNT_MIN    = 3;
    localparam int ROUND_SH   = 16;

    localparam logic [CFG_IW-1:0] REG_TARE   = 2'd0;
    localparam logic [CFG_IW-1:0] REG_CAL    = 2'd1;
    localparam logic [CFG_IW-1:0] REG_BAND   = 2'd2;
    localparam logic [CFG_IW-1:0] REG_WINDOW = 2'd3;

    localparam logic KIND_SAMPLE = 1'b0;
    localparam logic KIND_TARE   = 1'b1;

    typedef struct packed {
        logic                    kind;
        logic signed [RAW_W-1:0] raw_count;
        logic [31:0]             time_ms;
    } sample_t;

    typedef struct packed {
        logic signed [TENTHS_W-1:0] grams_tenths;
        logic                       is_stable;
        logic signed [RAW_W-1:0]    raw_echo;
        logic signed [RAW_W-1:0]    tare_now;
    } result_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL,
        ST_ROUND,
        ST_SUM_RD,
        ST_SUM_ACC,
        ST_DIV_SETUP,
        ST_DIV,
        ST_DIV_END,
        ST_HIST_WR,
        ST_HIST_RD,
        ST_HIST_ACC,
        ST_EVAL,
        ST_DONE
    } state_t;

endpackage

@@ hdl/lcas_if.sv @@
// ---------------------------------------------------------------------------
// lcas channel interfaces
// Valid/ready channels for sample items and result items
// ---------------------------------------------------------------------------
interface lcas_in_if;
    logic             valid;
    logic             ready;
    lcas_pkg::sample_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface lcas_out_if;
    logic             valid;
    logic             ready;
    lcas_pkg::result_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ hdl/load_cell_average_stability_core.sv @@
// ---------------------------------------------------------------------------
// load_cell_average_stability_core
// Tare, scale, moving average in tenths of a gram and window stability flag
// ---------------------------------------------------------------------------
// channel    | dir | payload
// sample_ch  | in  | kind, raw_count, time_ms
// result_ch  | out | grams_tenths, is_stable, raw_echo, tare_now
// cfg_*      | in  | write enable, register index, write data
//
// a tare item goes straight to the done state; a sample passes through
// the multiply and rounding, one bit-serial divider used twice and
// read-then-accumulate walks of both rings;
// below five history entries the history walk and its check are skipped
// result sits in an output register; the next item is taken while it waits
// rst_n clears control state and loads the register reset values
// ---------------------------------------------------------------------------
module load_cell_average_stability_core (
    input  logic                          clk,
    input  logic                          rst_n,
    lcas_in_if.sink                       sample_ch,
    lcas_out_if.source                    result_ch,
    input  logic                          cfg_we,
    input  logic [lcas_pkg::CFG_IW-1:0]   cfg_index,
    input  logic [lcas_pkg::CFG_DW-1:0]   cfg_wdata
);
    import lcas_pkg::*;

    state_t state_reg, state_next;

    logic signed [RAW_W-1:0]  tare_reg, last_raw_reg;
    logic signed [31:0]       cal_reg;
    logic [15:0]              band_reg, window_reg;

    logic signed [RAW_W-1:0]  raw_reg;
    logic [31:0]              time_reg;
    logic signed [PROD_W-1:0] prod_reg;

    logic [AVG_IW-1:0]        avg_next_reg, avg_idx_reg;
    logic [AVG_FW-1:0]        avg_fill_reg;
    logic [HIST_IW-1:0]       hist_next_reg, hist_idx_reg;
    logic [HIST_FW-1:0]       hist_fill_reg;

    logic signed [GRAM_W-1:0] avg_ring [AVG_DEPTH];
    logic signed [GRAM_W-1:0] hist_grams [HIST_DEPTH];
    logic [31:0]              hist_time [HIST_DEPTH];
    logic signed [GRAM_W-1:0] ring_rd_reg, hg_rd_reg;
    logic [31:0]              ht_rd_reg;

    logic signed [SUM_W-1:0]  sum_reg;
    logic                     neg_reg, div_sel_reg;
    logic [DIV_W-1:0]         quo_reg;
    logic [AVG_FW-1:0]        rem_reg;
    logic [DIV_CW-1:0]        div_cnt_reg;
    logic signed [GRAM_W-1:0] avg_reg, mn_reg, mx_reg;
    logic [HIST_FW-1:0]       cnt_reg;
    logic signed [TENTHS_W-1:0] tenths_reg;
    logic                     stable_reg;
    logic signed [RAW_W-1:0]  echo_reg;

    result_t                  out_reg;
    logic                     out_valid_reg;

    logic                     in_acc, avg_we, hist_we, out_load;
    logic                     avg_last, hist_last, hist_ready, div_go_on;
    logic signed [GRAM_W-1:0] g_val;
    logic [HIST_FW-1:0]       hist_fill_inc;
    logic [31:0]              cutoff;

    // rounding of the scaled reading to grams q.8 with saturation
    logic [PROD_W-1:0]        pmag;
    logic [PROD_W:0]          psum;
    logic [PROD_W-ROUND_SH:0] pq;
    logic [SUM_W-1:0]         smag;
    logic [DIV_W-1:0]         mag10;
    logic [AVG_FW:0]          rem_sh;

    always_comb
    begin
        pmag = prod_reg[PROD_W-1] ? PROD_W'(-prod_reg) : PROD_W'(prod_reg);
        psum = {1'b0, pmag} + (PROD_W+1)'(1 << (ROUND_SH - 1));
        pq   = psum[PROD_W:ROUND_SH];
        if (!prod_reg[PROD_W-1])
            g_val = (pq > (PROD_W-ROUND_SH+1)'(32'h7FFF_FFFF)) ? 32'sh7FFF_FFFF
                                                               : GRAM_W'(pq);
        else
            g_val = (pq > (PROD_W-ROUND_SH+1)'(33'h8000_0000)) ? 32'sh8000_0000
                                                               : GRAM_W'(-pq);
        smag   = sum_reg[SUM_W-1] ? SUM_W'(-sum_reg) : SUM_W'(sum_reg);
        mag10  = (DIV_W'(smag) << 3) + (DIV_W'(smag) << 1)
               + (DIV_W'(avg_fill_reg) << 7);
        rem_sh = {rem_reg, quo_reg[DIV_W-1]};
        cutoff = time_reg - 32'(window_reg);
        hist_fill_inc = (hist_fill_reg == HIST_FW'(HIST_DEPTH)) ? hist_fill_reg
                                                                : hist_fill_reg + 1'b1;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:      if (in_acc)
                              state_next = (sample_ch.data.kind == KIND_TARE) ? ST_DONE
                                                                               : ST_MUL;
            ST_MUL:       state_next = ST_ROUND;
            ST_ROUND:     state_next = ST_SUM_RD;
            ST_SUM_RD:    state_next = ST_SUM_ACC;
            ST_SUM_ACC:   state_next = avg_last ? ST_DIV_SETUP : ST_SUM_RD;
            ST_DIV_SETUP: state_next = ST_DIV;
            ST_DIV:       state_next = div_go_on ? ST_DIV : ST_DIV_END;
            ST_DIV_END:   state_next = div_sel_reg ? ST_HIST_WR : ST_DIV_SETUP;
            ST_HIST_WR:   state_next = hist_ready ? ST_HIST_RD : ST_DONE;
            ST_HIST_RD:   state_next = ST_HIST_ACC;
            ST_HIST_ACC:  state_next = hist_last ? ST_EVAL : ST_HIST_RD;
            ST_EVAL:      state_next = ST_DONE;
            ST_DONE:      if (out_load)
                              state_next = ST_IDLE;
            default:      state_next = ST_IDLE;
        endcase
    end

    // control outputs
    always_comb
    begin
        sample_ch.ready  = (state_reg == ST_IDLE);
        in_acc           = sample_ch.valid && (state_reg == ST_IDLE);
        avg_we           = (state_reg == ST_ROUND);
        hist_we          = (state_reg == ST_HIST_WR);
        out_load         = (state_reg == ST_DONE) && (!out_valid_reg || result_ch.ready);
        avg_last         = (AVG_FW'(avg_idx_reg) + 1'b1) == avg_fill_reg;
        hist_last        = (HIST_FW'(hist_idx_reg) + 1'b1) == hist_fill_reg;
        hist_ready       = hist_fill_inc >= HIST_FW'(HIST_MIN);
        div_go_on        = (div_cnt_reg != '0);
        result_ch.valid  = out_valid_reg;
        result_ch.data   = out_reg;
    end

    always_ff @(posedge clk)
    begin
        if (avg_we)
            avg_ring[avg_next_reg] <= g_val;
        ring_rd_reg <= avg_ring[avg_idx_reg];
    end

    always_ff @(posedge clk)
    begin
        if (hist_we)
        begin
            hist_grams[hist_next_reg] <= avg_reg;
            hist_time[hist_next_reg]  <= time_reg;
        end
        hg_rd_reg <= hist_grams[hist_idx_reg];
        ht_rd_reg <= hist_time[hist_idx_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            tare_reg      <= '0;
            cal_reg       <= 32'sd16777216;
            band_reg      <= 16'd512;
            window_reg    <= 16'd1000;
            last_raw_reg  <= '0;
            avg_next_reg  <= '0;
            avg_fill_reg  <= '0;
            hist_next_reg <= '0;
            hist_fill_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_TARE:   tare_reg   <= RAW_W'(cfg_wdata);
                    REG_CAL:    cal_reg    <= cfg_wdata;
                    REG_BAND:   band_reg   <= cfg_wdata[15:0];
                    REG_WINDOW: window_reg <= cfg_wdata[15:0];
                    default:    ;
                endcase
            end
            if (in_acc)
            begin
                if (sample_ch.data.kind == KIND_TARE)
                begin
                    if (last_raw_reg != '0)
                    begin
                        tare_reg      <= last_raw_reg;
                        avg_next_reg  <= '0;
                        avg_fill_reg  <= '0;
                        hist_next_reg <= '0;
                        hist_fill_reg <= '0;
                    end
                end
                else
                    last_raw_reg <= sample_ch.data.raw_count;
            end
            if (avg_we)
            begin
                avg_next_reg <= (avg_next_reg == AVG_IW'(AVG_DEPTH - 1)) ? '0
                                                                          : avg_next_reg + 1'b1;
                if (avg_fill_reg != AVG_FW'(AVG_DEPTH))
                    avg_fill_reg <= avg_fill_reg + 1'b1;
            end
            if (hist_we)
            begin
                hist_next_reg <= (hist_next_reg == HIST_IW'(HIST_DEPTH - 1)) ? '0
                                                                              : hist_next_reg + 1'b1;
                hist_fill_reg <= hist_fill_inc;
            end
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (result_ch.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                raw_reg    <= sample_ch.data.raw_count;
                time_reg   <= sample_ch.data.time_ms;
                tenths_reg <= '0;
                stable_reg <= 1'b0;
                echo_reg   <= (sample_ch.data.kind == KIND_TARE) ? last_raw_reg
                                                                  : sample_ch.data.raw_count;
            end
            ST_MUL:
                prod_reg <= PROD_W'((RAW_W+1)'(raw_reg) - (RAW_W+1)'(tare_reg)) * PROD_W'(cal_reg);
            ST_ROUND:
            begin
                avg_idx_reg <= '0;
                sum_reg     <= '0;
                div_sel_reg <= 1'b0;
            end
            ST_SUM_ACC:
            begin
                sum_reg     <= sum_reg + SUM_W'(ring_rd_reg);
                avg_idx_reg <= avg_idx_reg + 1'b1;
            end
            ST_DIV_SETUP:
            begin
                neg_reg     <= sum_reg[SUM_W-1];
                rem_reg     <= '0;
                div_cnt_reg <= DIV_CW'(DIV_W - 1);
                quo_reg     <= div_sel_reg ? (mag10 >> 8)
                                           : DIV_W'(smag) + DIV_W'(avg_fill_reg >> 1);
            end
            ST_DIV:
            begin
                div_cnt_reg <= div_cnt_reg - 1'b1;
                if (rem_sh >= {1'b0, avg_fill_reg})
                begin
                    rem_reg <= AVG_FW'(rem_sh - {1'b0, avg_fill_reg});
                    quo_reg <= {quo_reg[DIV_W-2:0], 1'b1};
                end
                else
                begin
                    rem_reg <= rem_sh[AVG_FW-1:0];
                    quo_reg <= {quo_reg[DIV_W-2:0], 1'b0};
                end
            end
            ST_DIV_END:
            begin
                div_sel_reg <= 1'b1;
                if (!div_sel_reg)
                    avg_reg <= neg_reg ? GRAM_W'(-quo_reg) : GRAM_W'(quo_reg);
                else if (quo_reg > DIV_W'(TENTHS_MAX))
                    tenths_reg <= neg_reg ? -TENTHS_W'(TENTHS_MAX) : TENTHS_W'(TENTHS_MAX);
                else
                    tenths_reg <= neg_reg ? TENTHS_W'(-quo_reg) : TENTHS_W'(quo_reg);
            end
            ST_HIST_WR:
            begin
                hist_idx_reg <= '0;
                cnt_reg      <= '0;
                mn_reg       <= '0;
                mx_reg       <= '0;
            end
            ST_HIST_ACC:
            begin
                hist_idx_reg <= hist_idx_reg + 1'b1;
                if (ht_rd_reg >= cutoff)
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == '0 || hg_rd_reg < mn_reg)
                        mn_reg <= hg_rd_reg;
                    if (cnt_reg == '0 || hg_rd_reg > mx_reg)
                        mx_reg <= hg_rd_reg;
                end
            end
            ST_EVAL:
                stable_reg <= (cnt_reg >= HIST_FW'(CNT_MIN))
                           && (33'(mx_reg - 33'(mn_reg)) < 33'(band_reg));
            ST_DONE:
            begin
                if (out_load)
                begin
                    out_reg.grams_tenths <= tenths_reg;
                    out_reg.is_stable    <= stable_reg;
                    out_reg.raw_echo     <= echo_reg;
                    out_reg.tare_now     <= tare_reg;
                end
            end
            default: ;
        endcase
    end

    a_sample_starts: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc && sample_ch.data.kind == KIND_SAMPLE |=> state_reg == ST_MUL)
        else $error("sample item did not start the multiply");

    a_avg_fill: assert property (@(posedge clk) disable iff (!rst_n)
        avg_fill_reg <= AVG_FW'(AVG_DEPTH))
        else $error("average fill count overflow");

    a_hist_fill: assert property (@(posedge clk) disable iff (!rst_n)
        hist_fill_reg <= HIST_FW'(HIST_DEPTH))
        else $error("history fill count overflow");

    a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == ST_DONE)
        else $error("result raised outside the done state");

endmodule
